// File: rtl/imf_pkg.sv
package imf_pkg;

   localparam int SIDE_DEFAULT      = 64;
   localparam int RAND_BITS_DEFAULT = 16;

   localparam int CMD_W     = 2;
   localparam int COORD_W   = 6;
   localparam int COORD_SPAN = 1 << COORD_W;
   localparam int RAND_W    = 16;
   localparam int THR_W     = 16;
   localparam int ENERGY_W  = 15;
   localparam int MAGNET_W  = 14;
   localparam int SUM_W     = 63;
   localparam int COUNT_W   = 32;
   localparam int CSR_IDX_W = 1;

   localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TRIAL = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RUN   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_THR_FOUR  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_THR_EIGHT = 1'd1;

   localparam logic [THR_W-1:0] THR_RESET = 16'hFFFF;

   // Control from the sequencer to the statistics unit.
   typedef struct packed {
      logic go;
      logic clear;
   } imf_stat_ctl_type;

endpackage

// File: rtl/ising_metropolis_flip.sv
// From accept to result an item passes three lattice read states on a RAM with two read ports,
// one update state, then (trial and begin-run only) a square and an accumulate state, then the
// output load, which waits until the output slot is free.
// The next item can be taken in the cycle after the output load; none is taken before that.
// Reset: spins are set up by a write pass over all 4**ceil(log2(SIDE)) RAM addresses (4096 at
// SIDE 64); no item is accepted until it ends.
module ising_metropolis_flip
   import imf_pkg::*;
#(
   parameter int SIDE      = SIDE_DEFAULT,
   parameter int RAND_BITS = RAND_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [THR_W-1:0]           csr_data,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [CMD_W-1:0]           req_cmd,
   input  logic [COORD_W-1:0]         req_row,
   input  logic [COORD_W-1:0]         req_column,
   input  logic                       req_spin_up,
   input  logic [RAND_W-1:0]          req_random_word,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_accepted,
   output logic signed [ENERGY_W-1:0] rsp_energy,
   output logic signed [MAGNET_W-1:0] rsp_magnetization,
   output logic signed [SUM_W-1:0]    rsp_energy_sum,
   output logic [SUM_W-1:0]           rsp_energy_square_sum,
   output logic signed [SUM_W-1:0]    rsp_magnet_sum,
   output logic [SUM_W-1:0]           rsp_magnet_square_sum,
   output logic [COUNT_W-1:0]         rsp_rejections
);

   localparam int SITES = SIDE * SIDE;
   localparam int CW    = $clog2(SIDE);
   localparam int AW    = 2 * CW;
   localparam int DEPTH = 1 << AW;
   localparam int EW    = $clog2(2 * SITES) + 2;
   localparam int MW    = $clog2(SITES) + 2;
   localparam int RWB   = (RAND_BITS < RAND_W) ? RAND_BITS : RAND_W;
   localparam int CMPW  = ((RAND_BITS > RAND_W) ? RAND_BITS : RAND_W) + THR_W;

   localparam logic [CW-1:0]        LAST_COORD   = CW'(SIDE - 1);
   localparam logic signed [EW-1:0] ENERGY_RESET = EW'(-2 * SITES);
   localparam logic signed [MW-1:0] MAGNET_RESET = MW'(SITES);
   localparam logic signed [MW-1:0] MAGNET_STEP  = MW'(2);

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_RD0   = 4'd2;
   localparam logic [3:0] ST_RD1   = 4'd3;
   localparam logic [3:0] ST_RD2   = 4'd4;
   localparam logic [3:0] ST_EXEC  = 4'd5;
   localparam logic [3:0] ST_SQR   = 4'd6;
   localparam logic [3:0] ST_ACC   = 4'd7;
   localparam logic [3:0] ST_DONE  = 4'd8;

   logic [3:0] state_ff, state_in;

   // Coordinate reduction modulo SIDE
   logic [CW-1:0] coord_mod [COORD_SPAN];
   for (genvar v = 0; v < COORD_SPAN; v++) begin : g_mod
      assign coord_mod[v] = CW'(v % SIDE);
   end

   logic [CMD_W-1:0]  cmd_ff;
   logic [CW-1:0]     r_ff, c_ff;
   logic              up_ff;
   logic [RAND_W-1:0] rw_ff;
   logic              s_ff, nu_ff, nd_ff, nl_ff;

   logic signed [EW-1:0] energy_ff, energy_in;
   logic signed [MW-1:0] magnet_ff, magnet_in;
   logic [COUNT_W-1:0]   reject_ff, reject_in;
   logic [THR_W-1:0]     thr_four_ff, thr_eight_ff;
   logic [AW-1:0]        clr_addr_ff;
   logic                 accepted_ff, accepted_in;

   logic                 rsp_valid_ff;
   logic                 accept_req;
   logic                 out_free;

   logic [CW-1:0]   r_up, r_dn, c_lf, c_rt;
   logic            ram_we, ram_wdata;
   logic [AW-1:0]   ram_waddr, ram_raddr_a, ram_raddr_b;
   logic            ram_rdata_a, ram_rdata_b;

   logic [2:0]           ups;
   logic                 rise, is_four, cmp_ok, ok, flip;
   logic signed [5:0]    de;
   logic [THR_W-1:0]     thr_sel;
   logic [CMPW-1:0]      rw_side, thr_side;

   imf_stat_ctl_type        stat_ctl;
   logic signed [SUM_W-1:0] esum, msum;
   logic [SUM_W-1:0]        esq_sum, msq_sum;

   assign req_ready  = (state_ff == ST_IDLE);
   assign accept_req = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // Neighbor coordinates with periodic wrap
   assign r_up = (r_ff == '0) ? LAST_COORD : r_ff - CW'(1);
   assign r_dn = (r_ff == LAST_COORD) ? '0 : r_ff + CW'(1);
   assign c_lf = (c_ff == '0) ? LAST_COORD : c_ff - CW'(1);
   assign c_rt = (c_ff == LAST_COORD) ? '0 : c_ff + CW'(1);

   always_comb begin
      ram_raddr_a = {r_ff, c_ff};
      ram_raddr_b = {r_up, c_ff};
      case (state_ff)
         ST_RD1: begin
            ram_raddr_a = {r_dn, c_ff};
            ram_raddr_b = {r_ff, c_lf};
         end
         ST_RD2: begin
            ram_raddr_a = {r_ff, c_rt};
            ram_raddr_b = {r_ff, c_ff};
         end
         default: begin
            ram_raddr_a = {r_ff, c_ff};
            ram_raddr_b = {r_up, c_ff};
         end
      endcase
   end

   // Local field and Metropolis decision; right neighbor arrives on port A
   always_comb begin
      ups     = 3'(nu_ff) + 3'(nd_ff) + 3'(nl_ff) + 3'(ram_rdata_a);
      rise    = s_ff ? (ups > 3'd2) : (ups < 3'd2);
      is_four = s_ff ? (ups == 3'd3) : (ups == 3'd1);
      de      = $signed({1'b0, ups, 2'b00}) - 6'sd8;
      if (!s_ff) de = -de;
      thr_sel  = is_four ? thr_four_ff : thr_eight_ff;
      rw_side  = CMPW'(rw_ff[RWB-1:0]) << RAND_W;
      thr_side = CMPW'(thr_sel) << RAND_BITS;
      cmp_ok   = (rw_side <= thr_side);
      ok       = !rise || cmp_ok;
      flip     = ((cmd_ff == CMD_LOAD) && (up_ff != s_ff)) ||
                 ((cmd_ff == CMD_TRIAL) && ok);
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = {r_ff, c_ff};
      ram_wdata = !s_ff;
      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_ff;
            ram_wdata = 1'b1;
         end
         ST_EXEC: begin
            ram_we = flip;
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   imf_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
   ) u_spin_ram (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (ram_waddr),
      .wr_data   (ram_wdata),
      .rd_addr_a (ram_raddr_a),
      .rd_data_a (ram_rdata_a),
      .rd_addr_b (ram_raddr_b),
      .rd_data_b (ram_rdata_b)
   );

   always_comb begin
      state_in    = state_ff;
      energy_in   = energy_ff;
      magnet_in   = magnet_ff;
      reject_in   = reject_ff;
      accepted_in = accepted_ff;
      case (state_ff)
         ST_CLEAR: if (clr_addr_ff == '1) state_in = ST_IDLE;
         ST_IDLE:  if (accept_req) state_in = ST_RD0;
         ST_RD0:   state_in = ST_RD1;
         ST_RD1:   state_in = ST_RD2;
         ST_RD2:   state_in = ST_EXEC;
         ST_EXEC: begin
            accepted_in = 1'b1;
            if (flip) begin
               energy_in = energy_ff + EW'(de);
               magnet_in = s_ff ? magnet_ff - MAGNET_STEP : magnet_ff + MAGNET_STEP;
            end
            if ((cmd_ff == CMD_TRIAL) && !ok) begin
               accepted_in = 1'b0;
               if (reject_ff != '1) reject_in = reject_ff + COUNT_W'(1);
            end
            if (cmd_ff == CMD_RUN) reject_in = '0;
            state_in = ((cmd_ff == CMD_TRIAL) || (cmd_ff == CMD_RUN)) ? ST_SQR : ST_DONE;
         end
         ST_SQR:  state_in = ST_ACC;
         ST_ACC:  state_in = ST_DONE;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign stat_ctl.go    = (state_ff == ST_SQR);
   assign stat_ctl.clear = (cmd_ff == CMD_RUN);

   imf_stats #(
      .EW (EW),
      .MW (MW)
   ) u_stats (
      .clock             (clock),
      .reset             (reset),
      .ctl               (stat_ctl),
      .energy            (energy_ff),
      .magnet            (magnet_ff),
      .energy_sum        (esum),
      .energy_square_sum (esq_sum),
      .magnet_sum        (msum),
      .magnet_square_sum (msq_sum)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         energy_ff    <= ENERGY_RESET;
         magnet_ff    <= MAGNET_RESET;
         reject_ff    <= '0;
         thr_four_ff  <= THR_RESET;
         thr_eight_ff <= THR_RESET;
         rsp_valid_ff <= 1'b0;
         accepted_ff  <= 1'b1;
      end else begin
         state_ff    <= state_in;
         energy_ff   <= energy_in;
         magnet_ff   <= magnet_in;
         reject_ff   <= reject_in;
         accepted_ff <= accepted_in;
         if (state_ff == ST_CLEAR) clr_addr_ff <= clr_addr_ff + AW'(1);
         if (csr_write_enable) begin
            case (csr_index)
               REG_THR_FOUR:  thr_four_ff  <= csr_data;
               REG_THR_EIGHT: thr_eight_ff <= csr_data;
               default: ;
            endcase
         end
         // Load a fresh beat when the output slot is free; drop a taken one
         if ((state_ff == ST_DONE) && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_req) begin
         cmd_ff <= req_cmd;
         r_ff   <= coord_mod[req_row];
         c_ff   <= coord_mod[req_column];
         up_ff  <= req_spin_up;
         rw_ff  <= req_random_word;
      end
      if (state_ff == ST_RD1) begin
         s_ff  <= ram_rdata_a;
         nu_ff <= ram_rdata_b;
      end
      if (state_ff == ST_RD2) begin
         nd_ff <= ram_rdata_a;
         nl_ff <= ram_rdata_b;
      end
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_accepted          <= accepted_ff;
         rsp_energy            <= ENERGY_W'(energy_ff);
         rsp_magnetization     <= MAGNET_W'(magnet_ff);
         rsp_energy_sum        <= esum;
         rsp_energy_square_sum <= esq_sum;
         rsp_magnet_sum        <= msum;
         rsp_magnet_square_sum <= msq_sum;
         rsp_rejections        <= reject_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result beat raised outside the output load step");

   a_reject_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_accepted) |-> (rsp_rejections != '0))
      else $error("rejected trial reported with a zero rejection count");

   a_ram_write_window: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> ((state_ff == ST_CLEAR) || (state_ff == ST_EXEC)))
      else $error("spin RAM written outside clear pass or update step");

   a_magnet_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |=> ((magnet_ff == $past(magnet_ff)) ||
                                 (magnet_ff == $past(magnet_ff) + MAGNET_STEP) ||
                                 (magnet_ff == $past(magnet_ff) - MAGNET_STEP)))
      else $error("magnetization moved by more than one spin flip");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |=> !(req_valid && req_ready && ($past(state_ff) == ST_CLEAR)
                                   && (state_ff == ST_CLEAR)))
      else $error("item accepted during the clear pass");

endmodule

// File: rtl/imf_ram.sv
module imf_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// File: rtl/imf_stats.sv
module imf_stats
   import imf_pkg::*;
#(
   parameter int EW = 15,
   parameter int MW = 14
) (
   input  logic                    clock,
   input  logic                    reset,
   input  imf_stat_ctl_type        ctl,
   input  logic signed [EW-1:0]    energy,
   input  logic signed [MW-1:0]    magnet,
   output logic signed [SUM_W-1:0] energy_sum,
   output logic        [SUM_W-1:0] energy_square_sum,
   output logic signed [SUM_W-1:0] magnet_sum,
   output logic        [SUM_W-1:0] magnet_square_sum
);

   localparam logic signed [63:0] SUM_MAX = 64'sh3FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] SUM_MIN = -SUM_MAX - 64'sd1;
   localparam logic [63:0]        SQ_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;

   // Stage one: squares
   logic                   go_ff;
   logic                   clear_ff;
   logic signed [EW-1:0]   e_ff;
   logic signed [MW-1:0]   m_ff;
   logic [2*EW-1:0]        esq_ff;
   logic [2*MW-1:0]        msq_ff;
   logic signed [2*EW-1:0] esq_in;
   logic signed [2*MW-1:0] msq_in;

   // Stage two: saturating sums
   logic signed [SUM_W-1:0] esum_ff, esum_in;
   logic [SUM_W-1:0]        esq_sum_ff, esq_sum_in;
   logic signed [SUM_W-1:0] msum_ff, msum_in;
   logic [SUM_W-1:0]        msq_sum_ff, msq_sum_in;

   logic signed [SUM_W-1:0] esum_base, msum_base;
   logic [SUM_W-1:0]        esq_base, msq_base;
   logic signed [63:0]      esum_wide, msum_wide;
   logic [63:0]             esq_wide, msq_wide;

   assign esq_in = energy * energy;
   assign msq_in = magnet * magnet;

   always_ff @(posedge clock) begin
      if (reset) begin
         go_ff <= 1'b0;
      end else begin
         go_ff <= ctl.go;
      end
      if (ctl.go) begin
         clear_ff <= ctl.clear;
         e_ff     <= energy;
         m_ff     <= magnet;
         esq_ff   <= esq_in;
         msq_ff   <= msq_in;
      end
   end

   always_comb begin
      esum_base = clear_ff ? '0 : esum_ff;
      msum_base = clear_ff ? '0 : msum_ff;
      esq_base  = clear_ff ? '0 : esq_sum_ff;
      msq_base  = clear_ff ? '0 : msq_sum_ff;

      esum_wide = 64'(esum_base) + 64'(e_ff);
      msum_wide = 64'(msum_base) + 64'(m_ff);
      esq_wide  = 64'(esq_base) + 64'(esq_ff);
      msq_wide  = 64'(msq_base) + 64'(msq_ff);

      esum_in = esum_ff;
      msum_in = msum_ff;
      esq_sum_in = esq_sum_ff;
      msq_sum_in = msq_sum_ff;
      if (go_ff) begin
         if (esum_wide > SUM_MAX) esum_in = SUM_W'(SUM_MAX);
         else if (esum_wide < SUM_MIN) esum_in = SUM_W'(SUM_MIN);
         else esum_in = SUM_W'(esum_wide);

         if (msum_wide > SUM_MAX) msum_in = SUM_W'(SUM_MAX);
         else if (msum_wide < SUM_MIN) msum_in = SUM_W'(SUM_MIN);
         else msum_in = SUM_W'(msum_wide);

         esq_sum_in = (esq_wide > SQ_MAX) ? SUM_W'(SQ_MAX) : SUM_W'(esq_wide);
         msq_sum_in = (msq_wide > SQ_MAX) ? SUM_W'(SQ_MAX) : SUM_W'(msq_wide);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esum_ff    <= '0;
         msum_ff    <= '0;
         esq_sum_ff <= '0;
         msq_sum_ff <= '0;
      end else begin
         esum_ff    <= esum_in;
         msum_ff    <= msum_in;
         esq_sum_ff <= esq_sum_in;
         msq_sum_ff <= msq_sum_in;
      end
   end

   assign energy_sum        = esum_ff;
   assign energy_square_sum = esq_sum_ff;
   assign magnet_sum        = msum_ff;
   assign magnet_square_sum = msq_sum_ff;

endmodule

// File: bench/ising_metropolis_flip_checker.sv
`timescale 1ns / 100ps

module ising_metropolis_flip_checker
   import imf_pkg::*;
#(
   parameter int SIDE      = SIDE_DEFAULT,
   parameter int RAND_BITS = RAND_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [THR_W-1:0]           csr_data,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [CMD_W-1:0]           req_cmd,
   input  logic [COORD_W-1:0]         req_row,
   input  logic [COORD_W-1:0]         req_column,
   input  logic                       req_spin_up,
   input  logic [RAND_W-1:0]          req_random_word,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic                       rsp_accepted,
   input  logic signed [ENERGY_W-1:0] rsp_energy,
   input  logic signed [MAGNET_W-1:0] rsp_magnetization,
   input  logic signed [SUM_W-1:0]    rsp_energy_sum,
   input  logic [SUM_W-1:0]           rsp_energy_square_sum,
   input  logic signed [SUM_W-1:0]    rsp_magnet_sum,
   input  logic [SUM_W-1:0]           rsp_magnet_square_sum,
   input  logic [COUNT_W-1:0]         rsp_rejections,
   output int                         mismatch_count,
   output int                         reports_in_flight
);

   localparam longint SUM_MAX = 64'sh3FFF_FFFF_FFFF_FFFF;
   localparam longint SUM_MIN = -SUM_MAX - 1;
   localparam longint unsigned SQUARE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic                accepted;
      logic [ENERGY_W-1:0] energy;
      logic [MAGNET_W-1:0] magnetization;
      logic [SUM_W-1:0]    energy_sum;
      logic [SUM_W-1:0]    energy_square_sum;
      logic [SUM_W-1:0]    magnet_sum;
      logic [SUM_W-1:0]    magnet_square_sum;
      logic [COUNT_W-1:0]  rejections;
   } flip_report_type;

   bit                lattice [SIDE*SIDE];
   int                energy_now;
   int                magnet_now;
   longint            energy_total;
   longint unsigned   energy_sq_total;
   longint            magnet_total;
   longint unsigned   magnet_sq_total;
   int unsigned       reject_total;
   logic [THR_W-1:0]  bound_four;
   logic [THR_W-1:0]  bound_eight;
   flip_report_type   lattice_reports [$];

   function automatic int site_spin(int r, int c);
      return lattice[(r % SIDE) * SIDE + (c % SIDE)] ? 1 : -1;
   endfunction

   function automatic longint clamp_sum(longint acc, longint v);
      longint s;
      s = acc + v;
      if (s > SUM_MAX) s = SUM_MAX;
      else if (s < SUM_MIN) s = SUM_MIN;
      return s;
   endfunction

   function automatic longint unsigned clamp_square(longint unsigned acc, longint v);
      longint unsigned m;
      longint unsigned s;
      m = (v < 0) ? -v : v;
      s = acc + m * m;
      return (s > SQUARE_MAX) ? SQUARE_MAX : s;
   endfunction

   function automatic void fold_into_sums();
      energy_total    = clamp_sum(energy_total, longint'(energy_now));
      energy_sq_total = clamp_square(energy_sq_total, longint'(energy_now));
      magnet_total    = clamp_sum(magnet_total, longint'(magnet_now));
      magnet_sq_total = clamp_square(magnet_sq_total, longint'(magnet_now));
   endfunction

   function automatic void flip_site(int idx, int old_spin, int nb);
      lattice[idx] = (old_spin < 0);
      energy_now   = energy_now + 2 * old_spin * nb;
      magnet_now   = magnet_now - 2 * old_spin;
   endfunction

   task automatic step_lattice(
      input  logic [CMD_W-1:0]   cmd,
      input  logic [COORD_W-1:0] row,
      input  logic [COORD_W-1:0] column,
      input  logic               spin_up,
      input  logic [RAND_W-1:0]  random_word,
      output flip_report_type    rep
   );
      int r;
      int c;
      int idx;
      int s;
      int nb;
      int rise;
      logic keep;
      longint unsigned draw;
      longint unsigned bound;
      r    = int'(row) % SIDE;
      c    = int'(column) % SIDE;
      idx  = r * SIDE + c;
      s    = lattice[idx] ? 1 : -1;
      nb   = site_spin(r + SIDE - 1, c) + site_spin(r + 1, c) +
             site_spin(r, c + SIDE - 1) + site_spin(r, c + 1);
      keep = 1'b1;
      case (cmd)
         CMD_LOAD: begin
            if (spin_up != (s > 0)) flip_site(idx, s, nb);
         end
         CMD_TRIAL: begin
            rise = 2 * s * nb;
            if (rise > 0) begin
               draw  = 64'(random_word);
               draw  = draw & ((64'd1 << RAND_BITS) - 64'd1);
               bound = (rise == 4) ? 64'(bound_four) : 64'(bound_eight);
               // compare both as fractions of one
               keep  = (draw << 16) <= (bound << RAND_BITS);
            end
            if (keep) flip_site(idx, s, nb);
            else if (reject_total != 32'hFFFF_FFFF) reject_total++;
            fold_into_sums();
         end
         CMD_RUN: begin
            energy_total    = 0;
            energy_sq_total = 0;
            magnet_total    = 0;
            magnet_sq_total = 0;
            reject_total    = 0;
            fold_into_sums();
         end
         default: ;
      endcase
      rep.accepted          = keep;
      rep.energy            = energy_now[ENERGY_W-1:0];
      rep.magnetization     = magnet_now[MAGNET_W-1:0];
      rep.energy_sum        = energy_total[SUM_W-1:0];
      rep.energy_square_sum = energy_sq_total[SUM_W-1:0];
      rep.magnet_sum        = magnet_total[SUM_W-1:0];
      rep.magnet_square_sum = magnet_sq_total[SUM_W-1:0];
      rep.rejections        = reject_total;
   endtask

   task automatic note_mismatch(input string what, input logic [63:0] seen,
                                input logic [63:0] wanted);
      $display("ising_metropolis_flip_tb: mismatch on %s at %0t: got %0h, want %0h",
               what, $time, seen, wanted);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : watch
      flip_report_type due;
      flip_report_type made;
      if (reset) begin
         foreach (lattice[i]) lattice[i] = 1'b1;
         energy_now        = -2 * SIDE * SIDE;
         magnet_now        = SIDE * SIDE;
         energy_total      = 0;
         energy_sq_total   = 0;
         magnet_total      = 0;
         magnet_sq_total   = 0;
         reject_total      = 0;
         bound_four        = THR_RESET;
         bound_eight       = THR_RESET;
         mismatch_count    = 0;
         lattice_reports.delete();
         reports_in_flight = 0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == REG_THR_FOUR) bound_four = csr_data;
            else if (csr_index == REG_THR_EIGHT) bound_eight = csr_data;
         end
         if (rsp_valid && rsp_ready) begin
            if (lattice_reports.size() == 0) begin
               note_mismatch("result beat with nothing outstanding", 64'd0, 64'd0);
            end else begin
               due = lattice_reports.pop_front();
               if (rsp_accepted !== due.accepted)
                  note_mismatch("accepted", 64'(rsp_accepted), 64'(due.accepted));
               if (rsp_energy !== due.energy)
                  note_mismatch("energy", 64'($unsigned(rsp_energy)), 64'(due.energy));
               if (rsp_magnetization !== due.magnetization)
                  note_mismatch("magnetization", 64'($unsigned(rsp_magnetization)),
                                64'(due.magnetization));
               if (rsp_energy_sum !== due.energy_sum)
                  note_mismatch("energy_sum", 64'($unsigned(rsp_energy_sum)),
                                64'(due.energy_sum));
               if (rsp_energy_square_sum !== due.energy_square_sum)
                  note_mismatch("energy_square_sum", 64'(rsp_energy_square_sum),
                                64'(due.energy_square_sum));
               if (rsp_magnet_sum !== due.magnet_sum)
                  note_mismatch("magnet_sum", 64'($unsigned(rsp_magnet_sum)),
                                64'(due.magnet_sum));
               if (rsp_magnet_square_sum !== due.magnet_square_sum)
                  note_mismatch("magnet_square_sum", 64'(rsp_magnet_square_sum),
                                64'(due.magnet_square_sum));
               if (rsp_rejections !== due.rejections)
                  note_mismatch("rejections", 64'(rsp_rejections), 64'(due.rejections));
            end
         end
         if (req_valid && req_ready) begin
            step_lattice(req_cmd, req_row, req_column, req_spin_up, req_random_word, made);
            lattice_reports.push_back(made);
         end
         reports_in_flight = lattice_reports.size();
      end
   end

endmodule

// File: bench/ising_metropolis_flip_tb.sv
`timescale 1ns / 100ps

module ising_metropolis_flip_tb
   import imf_pkg::*;
();

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int STALL_LIMIT  = 20000;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASES       = 6;
   localparam int PHASE_BEATS  = 200;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [THR_W-1:0]           csr_data = '0;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [CMD_W-1:0]           req_cmd = '0;
   logic [COORD_W-1:0]         req_row = '0;
   logic [COORD_W-1:0]         req_column = '0;
   logic                       req_spin_up = 1'b0;
   logic [RAND_W-1:0]          req_random_word = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_accepted;
   logic signed [ENERGY_W-1:0] rsp_energy;
   logic signed [MAGNET_W-1:0] rsp_magnetization;
   logic signed [SUM_W-1:0]    rsp_energy_sum;
   logic [SUM_W-1:0]           rsp_energy_square_sum;
   logic signed [SUM_W-1:0]    rsp_magnet_sum;
   logic [SUM_W-1:0]           rsp_magnet_square_sum;
   logic [COUNT_W-1:0]         rsp_rejections;

   int mismatch_count;
   int reports_in_flight;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_trigger   = 0;
   int hold_seen      = 0;
   int hold_left      = 0;
   int quiet_cycles   = 0;

   logic [THR_W-1:0] cur_four  = THR_RESET;
   logic [THR_W-1:0] cur_eight = THR_RESET;
   int load_beats    = 0;
   int trial_beats   = 0;
   int run_beats     = 0;
   int unused_beats  = 0;
   int settings_done = 0;

   always #5 clock = ~clock;

   ising_metropolis_flip u_top (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_cmd               (req_cmd),
      .req_row               (req_row),
      .req_column            (req_column),
      .req_spin_up           (req_spin_up),
      .req_random_word       (req_random_word),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_accepted          (rsp_accepted),
      .rsp_energy            (rsp_energy),
      .rsp_magnetization     (rsp_magnetization),
      .rsp_energy_sum        (rsp_energy_sum),
      .rsp_energy_square_sum (rsp_energy_square_sum),
      .rsp_magnet_sum        (rsp_magnet_sum),
      .rsp_magnet_square_sum (rsp_magnet_square_sum),
      .rsp_rejections        (rsp_rejections)
   );

   ising_metropolis_flip_checker u_checker (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_cmd               (req_cmd),
      .req_row               (req_row),
      .req_column            (req_column),
      .req_spin_up           (req_spin_up),
      .req_random_word       (req_random_word),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_accepted          (rsp_accepted),
      .rsp_energy            (rsp_energy),
      .rsp_magnetization     (rsp_magnetization),
      .rsp_energy_sum        (rsp_energy_sum),
      .rsp_energy_square_sum (rsp_energy_square_sum),
      .rsp_magnet_sum        (rsp_magnet_sum),
      .rsp_magnet_square_sum (rsp_magnet_square_sum),
      .rsp_rejections        (rsp_rejections),
      .mismatch_count        (mismatch_count),
      .reports_in_flight     (reports_in_flight)
   );

   // result side: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_trigger != hold_seen) begin
         hold_seen <= hold_trigger;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("ising_metropolis_flip_tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [COORD_W-1:0] pick_coord();
      // cluster on the corner so neighbors interact and the wrap is crossed
      if ($urandom_range(9) < 7) return COORD_W'(COORD_SPAN - 2 + $urandom_range(4));
      return COORD_W'($urandom);
   endfunction

   task automatic send_beat(
      input logic [CMD_W-1:0]   cmd,
      input logic [COORD_W-1:0] row,
      input logic [COORD_W-1:0] column,
      input logic               spin_up,
      input logic [RAND_W-1:0]  random_word
   );
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_row         <= row;
      req_column      <= column;
      req_spin_up     <= spin_up;
      req_random_word <= random_word;
      if (cmd == CMD_LOAD) load_beats++;
      else if (cmd == CMD_TRIAL) trial_beats++;
      else if (cmd == CMD_RUN) run_beats++;
      else unused_beats++;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random_beat();
      logic [CMD_W-1:0]  cmd;
      logic [RAND_W-1:0] word;
      int pick;
      pick = $urandom_range(99);
      if (pick < 60) cmd = CMD_TRIAL;
      else if (pick < 88) cmd = CMD_LOAD;
      else if (pick < 95) cmd = CMD_RUN;
      else cmd = CMD_UNUSED;
      // lean on the threshold edges
      case ($urandom_range(7))
         0: word = cur_four;
         1: word = cur_four + 1'b1;
         2: word = cur_eight;
         3: word = cur_eight + 1'b1;
         4: word = '0;
         5: word = '1;
         default: word = RAND_W'($urandom);
      endcase
      send_beat(cmd, pick_coord(), pick_coord(), 1'($urandom), word);
   endtask

   task automatic drain_reports();
      req_valid <= 1'b0;
      @(negedge clock);
      while (reports_in_flight != 0) @(negedge clock);
   endtask

   task automatic write_thresholds(input logic [THR_W-1:0] four, input logic [THR_W-1:0] eight);
      csr_write_enable <= 1'b1;
      csr_index        <= REG_THR_FOUR;
      csr_data         <= four;
      @(negedge clock);
      csr_index        <= REG_THR_EIGHT;
      csr_data         <= eight;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      cur_four  = four;
      cur_eight = eight;
      settings_done++;
   endtask

   initial begin : stimulus
      int phase;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset thresholds: both bounds at full scale
      send_beat(CMD_UNUSED, 6'd0, 6'd0, 1'b0, 16'h0000);
      send_beat(CMD_RUN, 6'd63, 6'd63, 1'b1, 16'hFFFF);
      send_beat(CMD_LOAD, 6'd0, 6'd0, 1'b1, 16'h0000);
      send_beat(CMD_TRIAL, 6'd0, 6'd0, 1'b0, 16'hFFFF);
      send_beat(CMD_TRIAL, 6'd0, 6'd0, 1'b1, 16'hFFFF);
      send_beat(CMD_LOAD, 6'd0, 6'd63, 1'b0, 16'h1111);
      send_beat(CMD_LOAD, 6'd63, 6'd0, 1'b0, 16'h2222);
      send_beat(CMD_TRIAL, 6'd0, 6'd0, 1'b0, 16'h1234);
      send_beat(CMD_LOAD, 6'd0, 6'd0, 1'b1, 16'h4321);
      drain_reports();

      // tight bounds: accept only at or below them
      write_thresholds(16'h0001, 16'h0000);
      send_beat(CMD_TRIAL, 6'd5, 6'd5, 1'b0, 16'h0000);
      send_beat(CMD_TRIAL, 6'd5, 6'd6, 1'b1, 16'h0001);
      send_beat(CMD_TRIAL, 6'd5, 6'd7, 1'b0, 16'h0002);
      send_beat(CMD_TRIAL, 6'd9, 6'd9, 1'b1, 16'h0001);
      send_beat(CMD_RUN, 6'd0, 6'd0, 1'b0, 16'h5A5A);
      send_beat(CMD_LOAD, 6'd63, 6'd63, 1'b0, 16'hA5A5);
      send_beat(CMD_TRIAL, 6'd63, 6'd63, 1'b1, 16'hFFFF);
      send_beat(CMD_UNUSED, 6'd63, 6'd63, 1'b1, 16'hFFFF);
      drain_reports();

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: write_thresholds(16'h8000, 16'h1000);
            1: write_thresholds('0, '0);
            2: write_thresholds('1, '1);
            3: write_thresholds('1, '0);
            4: write_thresholds('0, '1);
            default: write_thresholds(THR_W'($urandom), THR_W'($urandom));
         endcase
         case (phase % 4)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct <= 0;
            end
            1: begin
               send_idle_pct = 47;
               recv_stall_pct <= 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct <= 47;
            end
            default: begin
               send_idle_pct = 34;
               recv_stall_pct <= 34;
            end
         endcase
         for (int n = 0; n < PHASE_BEATS; n++) begin
            // back up the block while requests keep coming
            if (phase == 4 && n == 50) hold_trigger <= hold_trigger + 1;
            send_random_beat();
         end
         drain_reports();
      end

      repeat (16) @(negedge clock);
      $display("ising_metropolis_flip_tb: sent %0d loads, %0d trials, %0d run starts, %0d unused",
               load_beats, trial_beats, run_beats, unused_beats);
      $display("ising_metropolis_flip_tb: %0d threshold settings, four idle mixes, %0d-cycle hold",
               settings_done, HOLD_CYCLES);
      if (mismatch_count == 0) begin
         $display("ising_metropolis_flip_tb: clean");
      end else begin
         $display("ising_metropolis_flip_tb: errors");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/imf_pkg.sv
rtl/imf_ram.sv
rtl/imf_stats.sv
rtl/ising_metropolis_flip.sv
bench/ising_metropolis_flip_checker.sv
bench/ising_metropolis_flip_tb.sv
